// File: rtl/hpq_pkg.sv
// shared types and constants of the max-heap priority queue
// no dependencies; imported by every other file of the block but hpq_ram
`default_nettype none

package hpq_pkg;

  localparam int unsigned HPQ_CAPACITY  = 64;
  localparam int unsigned HPQ_KEY_WIDTH = 16;
  localparam int unsigned HPQ_QDEPTH    = 2;

  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned STATUS_W = 2;

  localparam logic       CMD_INSERT  = 1'b0;
  localparam logic       CMD_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // class of a command as the front end decides it
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_EXTRACT,
    OP_ERR_EMPTY,
    OP_ERR_FULL
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } q_item_t;

  typedef struct packed {
    logic    vld;
    q_item_t item;
  } q_word_t;

endpackage

`default_nettype wire

// File: rtl/hpq_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module hpq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/hpq_fifo.sv
// short command queue between front end and heap engine
// depends on hpq_pkg for the queued word type
`default_nettype none

module hpq_fifo import hpq_pkg::*; #(
  parameter int unsigned DEPTH = HPQ_QDEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_word_t push_i,
  input  wire logic    pop_i,
  output q_word_t      head_o,
  output logic         full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_item_t         mem_q [DEPTH];
  logic [PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign do_push = push_i.vld && (cnt_q != CW'(DEPTH));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.item;
    end
  end

  assign head_o.vld  = (cnt_q != '0);
  assign head_o.item = mem_q[rptr_q];
  assign full_o      = (cnt_q == CW'(DEPTH));

endmodule

`default_nettype wire

// File: rtl/hpq_front.sv
// front end: takes commands and classifies them against a projected fill level
// depends on hpq_pkg
`default_nettype none

module hpq_front import hpq_pkg::*; #(
  parameter int unsigned CAPACITY = HPQ_CAPACITY
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              command_i,
  input  wire logic [PRIO_W-1:0] priority_req_i,
  input  wire logic [TAG_W-1:0]  payload_tag_i,
  input  wire logic              q_full_i,
  output logic                   busy_o,
  output q_word_t                push_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] proj_q, proj_d;
  logic          accept;
  op_e           op;

  assign busy_o = q_full_i;
  assign accept = start_i && !q_full_i;

  always_comb begin
    proj_d = proj_q;
    if (command_i == CMD_INSERT) begin
      if (proj_q == CW'(CAPACITY)) begin
        op = OP_ERR_FULL;
      end else begin
        op = OP_INSERT;
        if (accept) proj_d = proj_q + 1'b1;
      end
    end else begin
      if (proj_q == '0) begin
        op = OP_ERR_EMPTY;
      end else begin
        op = OP_EXTRACT;
        if (accept) proj_d = proj_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proj_q <= '0;
    end else begin
      proj_q <= proj_d;
    end
  end

  assign push_o.vld       = accept;
  assign push_o.item.op   = op;
  assign push_o.item.prio = priority_req_i;
  assign push_o.item.tag  = payload_tag_i;

endmodule

`default_nettype wire

// File: rtl/hpq_back.sv
// heap engine: runs sift-up and sift-down over the heap ram, one result per command
// depends on hpq_pkg and hpq_ram
`default_nettype none

module hpq_back import hpq_pkg::*; #(
  parameter int unsigned CAPACITY  = HPQ_CAPACITY,
  parameter int unsigned KEY_WIDTH = HPQ_KEY_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire q_word_t                        head_i,
  output logic                                pop_o,
  output logic                                done_o,
  output logic [STATUS_W-1:0]                 status_o,
  output logic [PRIO_W-1:0]                   out_priority_o,
  output logic [TAG_W-1:0]                    out_tag_o,
  output logic [$clog2(CAPACITY + 1)-1:0]     occupancy_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_WIDTH + TAG_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_PLACE,
    ST_EX_ROOT,
    ST_EX_LAST,
    ST_EX_MOV,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP
  } state_e;

  state_e                state_q, state_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [KEY_WIDTH-1:0]  mov_key_q, mov_key_d, lft_key_q, lft_key_d;
  logic [TAG_W-1:0]      mov_tag_q, mov_tag_d, lft_tag_q, lft_tag_d;
  logic                  done_q, done_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [PRIO_W-1:0]     opri_q, opri_d;
  logic [TAG_W-1:0]      otag_q, otag_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [EW-1:0]         ram_wdata, ram_rdata;
  logic [KEY_WIDTH-1:0]  rd_key;
  logic [TAG_W-1:0]      rd_tag;

  logic [AW:0]           left_idx, right_idx, cnt_ext;
  logic                  left_ok, right_ok, use_r;
  logic [AW-1:0]         parent;
  logic [KEY_WIDTH-1:0]  child_key;
  logic [TAG_W-1:0]      child_tag;
  logic [AW-1:0]         child_idx;

  hpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key = ram_rdata[EW-1:TAG_W];
  assign rd_tag = ram_rdata[TAG_W-1:0];

  assign left_idx  = {pos_q, 1'b1};
  assign right_idx = left_idx + 1'b1;
  assign cnt_ext   = (AW + 1)'(cnt_q);
  assign left_ok   = left_idx < cnt_ext;
  assign right_ok  = right_idx < cnt_ext;
  assign parent    = AW'((pos_q - 1'b1) >> 1);

  // larger child, left wins ties
  assign use_r     = right_ok && (rd_key > lft_key_q);
  assign child_key = use_r ? rd_key : lft_key_q;
  assign child_tag = use_r ? rd_tag : lft_tag_q;
  assign child_idx = use_r ? right_idx[AW-1:0] : left_idx[AW-1:0];

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    mov_key_d = mov_key_q;
    mov_tag_d = mov_tag_q;
    lft_key_d = lft_key_q;
    lft_tag_d = lft_tag_q;
    done_d    = 1'b0;
    status_d  = status_q;
    opri_d    = opri_q;
    otag_d    = otag_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = {mov_key_q, mov_tag_q};
    ram_raddr = '0;

    case (state_q)
      ST_IDLE: begin
        if (head_i.vld) begin
          pop_o    = 1'b1;
          status_d = STATUS_OK;
          opri_d   = '0;
          otag_d   = '0;
          case (head_i.item.op)
            OP_ERR_EMPTY: begin
              status_d = STATUS_EMPTY;
              done_d   = 1'b1;
            end
            OP_ERR_FULL: begin
              status_d = STATUS_FULL;
              done_d   = 1'b1;
            end
            OP_INSERT: begin
              mov_key_d = KEY_WIDTH'(head_i.item.prio);
              mov_tag_d = head_i.item.tag;
              cnt_d     = cnt_q + 1'b1;
              pos_d     = AW'(cnt_q);
              if (cnt_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {KEY_WIDTH'(head_i.item.prio), head_i.item.tag};
                done_d    = 1'b1;
              end else begin
                state_d = ST_UP_RD;
              end
            end
            OP_EXTRACT: begin
              cnt_d   = cnt_q - 1'b1;
              state_d = ST_EX_ROOT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_UP_RD: begin
        ram_raddr = parent;
        state_d   = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        ram_we = 1'b1;
        if (mov_key_q > rd_key) begin
          ram_wdata = ram_rdata;
          pos_d     = parent;
          state_d   = (parent == '0) ? ST_PLACE : ST_UP_RD;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_PLACE: begin
        ram_we  = 1'b1;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_EX_ROOT: begin
        ram_raddr = '0;
        state_d   = ST_EX_LAST;
      end
      ST_EX_LAST: begin
        ram_raddr = AW'(cnt_q);
        opri_d    = PRIO_W'(rd_key);
        otag_d    = rd_tag;
        state_d   = ST_EX_MOV;
      end
      ST_EX_MOV: begin
        mov_key_d = rd_key;
        mov_tag_d = rd_tag;
        pos_d     = '0;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DN_L;
        end
      end
      ST_DN_L: begin
        if (left_ok) begin
          ram_raddr = left_idx[AW-1:0];
          state_d   = ST_DN_R;
        end else begin
          ram_we  = 1'b1;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DN_R: begin
        ram_raddr = right_idx[AW-1:0];
        lft_key_d = rd_key;
        lft_tag_d = rd_tag;
        state_d   = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        ram_we = 1'b1;
        if (child_key > mov_key_q) begin
          ram_wdata = {child_key, child_tag};
          pos_d     = child_idx;
          state_d   = ST_DN_L;
        end else begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
      opri_q   <= '0;
      otag_q   <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      status_q <= status_d;
      opri_q   <= opri_d;
      otag_q   <= otag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    mov_key_q <= mov_key_d;
    mov_tag_q <= mov_tag_d;
    lft_key_q <= lft_key_d;
    lft_tag_q <= lft_tag_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_priority_o = opri_q;
  assign out_tag_o      = otag_q;
  assign occupancy_o    = cnt_q;

endmodule

`default_nettype wire

// File: rtl/max_heap_priority_queue_core.sv
// top level of the binary max-heap priority queue
// depends on hpq_pkg, hpq_front, hpq_fifo, hpq_back (which holds hpq_ram)
//
// a command word (insert of priority and tag, or extract-max) is taken at a
// rising edge with start_i high and busy_o low. every command gives exactly
// one result word, shown for one cycle with done_o high; the receiver cannot
// stall, so results must be sampled on the cycle they appear. results come in
// command order. the front end classifies commands as they arrive (insert into
// a full queue, extract from an empty one) and drops them in a two-word queue;
// busy_o is high only while that queue is full. the heap engine works one
// command at a time on a single ram with one write and one registered read
// port. a taken word waits in that queue until the idle engine pops it. error
// commands touch no ram. an insert climbs: per level it reads the parent and
// compares, moving a smaller parent down, then writes the word where it stops
// or at the root. an extract reads root and last entry, then per level reads
// both children and compares, moving the larger up, until a leaf or no larger
// child ends it with a write. the result is registered and shows in the cycle
// after the engine finishes. the ram is not cleared: unfilled slots go unused.
`default_nettype none

module max_heap_priority_queue_core import hpq_pkg::*; #(
  parameter int unsigned CAPACITY  = HPQ_CAPACITY,
  parameter int unsigned KEY_WIDTH = HPQ_KEY_WIDTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  output logic                             busy_o,
  input  wire logic                        command_i,
  input  wire logic [PRIO_W-1:0]           priority_req_i,
  input  wire logic [TAG_W-1:0]            payload_tag_i,
  output logic                             done_o,
  output logic [STATUS_W-1:0]              status_o,
  output logic [PRIO_W-1:0]                out_priority_o,
  output logic [TAG_W-1:0]                 out_tag_o,
  output logic [$clog2(CAPACITY + 1)-1:0]  occupancy_o
);

  // queued command words between front end and engine
  q_word_t push_w;
  q_word_t head_w;
  logic    q_full;
  logic    pop;

  // classification uses a projected fill level that runs ahead of the engine
  hpq_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .command_i      (command_i),
    .priority_req_i (priority_req_i),
    .payload_tag_i  (payload_tag_i),
    .q_full_i       (q_full),
    .busy_o         (busy_o),
    .push_o         (push_w)
  );

  hpq_fifo #(
    .DEPTH (HPQ_QDEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_w),
    .pop_i  (pop),
    .head_o (head_w),
    .full_o (q_full)
  );

  // heap engine, owns the heap ram and the true entry count
  hpq_back #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_w),
    .pop_o          (pop),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_tag_o      (out_tag_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

`default_nettype wire

// File: bench/max_heap_priority_queue_core_tb.sv
// self-checking bench for max_heap_priority_queue_core: random and directed command words
// depends on hpq_pkg and the rtl of the block; a shadow heap predicts every result word
`default_nettype none

module max_heap_priority_queue_core_tb;
  import hpq_pkg::*;

  localparam int unsigned OCC_W          = $clog2(HPQ_CAPACITY + 1);
  localparam int unsigned TOTAL_WORDS    = 1850;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 50;
  localparam logic [PRIO_W-1:0] KEY_MASK = PRIO_W'((64'd1 << HPQ_KEY_WIDTH) - 1);

  // one command word waiting to be sent, with the idle cycles that follow it
  typedef struct {
    logic              cmd;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
    int unsigned       gap;
  } cmd_word_t;

  // one predicted result word
  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   prio;
    logic [TAG_W-1:0]    tag;
    logic [OCC_W-1:0]    occ;
  } heap_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                command_i = CMD_INSERT;
  logic [PRIO_W-1:0]   priority_req_i = '0;
  logic [TAG_W-1:0]    payload_tag_i = '0;
  logic                busy_o;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [PRIO_W-1:0]   out_priority_o;
  logic [TAG_W-1:0]    out_tag_o;
  logic [OCC_W-1:0]    occupancy_o;

  max_heap_priority_queue_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .priority_req_i (priority_req_i),
    .payload_tag_i  (payload_tag_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_tag_o      (out_tag_o),
    .occupancy_o    (occupancy_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // words still to send, and result words predicted but not yet seen
  cmd_word_t    send_queue[$];
  heap_result_t result_queue[$];

  // shadow copy of the heap, kept in array order like the block
  logic [PRIO_W-1:0] shadow_key [HPQ_CAPACITY];
  logic [TAG_W-1:0]  shadow_tag [HPQ_CAPACITY];
  int unsigned       shadow_count = 0;

  // bookkeeping for the stimulus plan and the summary
  int unsigned plan_occ = 0;
  int unsigned plan_gap_max = 8;
  int unsigned error_count = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned inserts_ok = 0;
  int unsigned extracts_ok = 0;
  int unsigned full_rejects = 0;
  int unsigned empty_rejects = 0;
  int unsigned peak_occ = 0;
  int unsigned cur_gap = 0;
  int unsigned idle_left = 0;
  int unsigned quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // shadow heap
  // ---------------------------------------------------------------------------

  task automatic swap_entries(input int unsigned a, input int unsigned b);
    logic [PRIO_W-1:0] k;
    logic [TAG_W-1:0]  t;
    k = shadow_key[a];
    t = shadow_tag[a];
    shadow_key[a] = shadow_key[b];
    shadow_tag[a] = shadow_tag[b];
    shadow_key[b] = k;
    shadow_tag[b] = t;
  endtask

  // apply one accepted command word to the shadow heap and queue its result
  task automatic predict_heap_op(input logic cmd, input logic [PRIO_W-1:0] prio,
                                 input logic [TAG_W-1:0] tag);
    heap_result_t r;
    int unsigned  pos;
    int unsigned  parent;
    int unsigned  left;
    int unsigned  right;
    int unsigned  best;
    r.status = STATUS_OK;
    r.prio   = '0;
    r.tag    = '0;
    if (cmd == CMD_INSERT) begin
      if (shadow_count >= HPQ_CAPACITY) begin
        // full queue: nothing changes
        r.status = STATUS_FULL;
        full_rejects++;
      end else begin
        pos = shadow_count;
        shadow_key[pos] = prio & KEY_MASK;
        shadow_tag[pos] = tag;
        shadow_count++;
        inserts_ok++;
        // climb only past a strictly smaller parent
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (shadow_key[pos] <= shadow_key[parent]) break;
          swap_entries(pos, parent);
          pos = parent;
        end
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STATUS_EMPTY;
        empty_rejects++;
      end else begin
        r.prio = shadow_key[0];
        r.tag  = shadow_tag[0];
        shadow_count--;
        extracts_ok++;
        if (shadow_count > 0) begin
          shadow_key[0] = shadow_key[shadow_count];
          shadow_tag[0] = shadow_tag[shadow_count];
          pos = 0;
          // descend toward the larger child, left wins ties, equal never swaps
          while (pos < shadow_count) begin
            left  = 2 * pos + 1;
            right = left + 1;
            best  = pos;
            if (left < shadow_count && shadow_key[left] > shadow_key[best]) best = left;
            if (right < shadow_count && shadow_key[right] > shadow_key[best]) best = right;
            if (best == pos) break;
            swap_entries(pos, best);
            pos = best;
          end
        end
      end
    end
    r.occ = OCC_W'(shadow_count);
    if (shadow_count > peak_occ) peak_occ = shadow_count;
    result_queue.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus plan
  // ---------------------------------------------------------------------------

  // key styles: full range, a tiny range full of ties, the extremes, a narrow band
  function automatic logic [PRIO_W-1:0] draw_key(input int unsigned style);
    logic [PRIO_W-1:0] k;
    case (style)
      0: k = PRIO_W'($urandom);
      1: k = PRIO_W'($urandom_range(0, 3));
      2: begin
        case ($urandom_range(0, 3))
          0: k = '0;
          1: k = '1;
          2: k = PRIO_W'(16'h8000);
          default: k = PRIO_W'(16'h7FFF);
        endcase
      end
      default: k = PRIO_W'(16'h8000 + $urandom_range(0, 15));
    endcase
    return k;
  endfunction

  // append a word to the send queue, tracking how full the queue will be
  task automatic plan_word(input logic cmd, input logic [PRIO_W-1:0] prio,
                           input logic [TAG_W-1:0] tag);
    cmd_word_t w;
    w.cmd  = cmd;
    w.prio = prio;
    w.tag  = tag;
    w.gap  = $urandom_range(0, plan_gap_max);
    send_queue.push_back(w);
    if (cmd == CMD_INSERT && plan_occ < HPQ_CAPACITY) plan_occ++;
    if (cmd == CMD_EXTRACT && plan_occ > 0) plan_occ--;
  endtask

  initial begin : stimulus
    int unsigned style;
    int unsigned run;

    // directed opening: empty extract, extreme keys, equal keys, then drain past empty
    plan_gap_max = 3;
    plan_word(CMD_EXTRACT, 16'hFFFF, 16'hFFFF);
    plan_word(CMD_INSERT, 16'h0000, 16'h0000);
    plan_word(CMD_INSERT, 16'hFFFF, 16'hFFFF);
    plan_word(CMD_INSERT, 16'h8000, 16'h0001);
    plan_word(CMD_INSERT, 16'h8000, 16'h0002);
    plan_word(CMD_INSERT, 16'h8000, 16'h0003);
    plan_word(CMD_INSERT, 16'h0001, 16'hA5A5);
    plan_word(CMD_INSERT, 16'hFFFF, 16'h5A5A);
    repeat (8) plan_word(CMD_EXTRACT, 16'h5555, 16'hAAAA);
    plan_word(CMD_INSERT, 16'h7FFF, 16'h8000);
    plan_word(CMD_INSERT, 16'h7FFF, 16'h7FFF);
    plan_word(CMD_EXTRACT, 16'h0000, 16'h0000);
    plan_word(CMD_EXTRACT, 16'h0000, 16'h0000);

    // random part: fill to full, drain to empty, and mixed runs around the middle
    while (send_queue.size() < TOTAL_WORDS) begin
      plan_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      style = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0: begin
          while (plan_occ < HPQ_CAPACITY)
            plan_word(CMD_INSERT, draw_key(style), TAG_W'($urandom));
          run = $urandom_range(1, 3);
          repeat (run) plan_word(CMD_INSERT, draw_key(0), TAG_W'($urandom));
        end
        1: begin
          while (plan_occ > 0)
            plan_word(CMD_EXTRACT, PRIO_W'($urandom), TAG_W'($urandom));
          run = $urandom_range(1, 2);
          repeat (run) plan_word(CMD_EXTRACT, PRIO_W'($urandom), TAG_W'($urandom));
        end
        default: begin
          run = $urandom_range(10, 60);
          repeat (run) begin
            // lean toward inserts when low and extracts when high
            if ($urandom_range(0, HPQ_CAPACITY) >= plan_occ)
              plan_word(CMD_INSERT, draw_key(style), TAG_W'($urandom));
            else
              plan_word(CMD_EXTRACT, PRIO_W'($urandom), TAG_W'($urandom));
          end
        end
      endcase
    end

    // reset held from time zero, released at a rising edge
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait until every word went out and every result came back
    while (send_queue.size() != 0 || start_i || result_queue.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (result_queue.size() != 0) begin
      $display("%0t: tb %0d result words never arrived", $time, result_queue.size());
      error_count++;
    end

    $display("tb: %0d words sent, %0d results checked, %0d inserts and %0d extracts done",
             words_sent, results_seen, inserts_ok, extracts_ok);
    $display("tb: %0d full-queue rejects, %0d empty-queue rejects, peak occupancy %0d",
             full_rejects, empty_rejects, peak_occ);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: a word stays on the ports until taken, then its gap is spent idle
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    int unsigned wait_n;
    cmd_word_t   w;
    if (!rst_ni) begin
      start_i        <= 1'b0;
      command_i      <= CMD_INSERT;
      priority_req_i <= '0;
      payload_tag_i  <= '0;
      idle_left      <= 0;
      cur_gap        <= 0;
    end else if (!(start_i && busy_o)) begin
      if (start_i) begin
        // word taken at this edge
        predict_heap_op(command_i, priority_req_i, payload_tag_i);
        words_sent++;
      end
      wait_n = start_i ? cur_gap : idle_left;
      if (wait_n > 0) begin
        start_i   <= 1'b0;
        idle_left <= wait_n - 1;
      end else if (send_queue.size() > 0) begin
        w = send_queue.pop_front();
        start_i        <= 1'b1;
        command_i      <= w.cmd;
        priority_req_i <= w.prio;
        payload_tag_i  <= w.tag;
        cur_gap        <= w.gap;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every done cycle carries one result word, checked in order
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: tb %s mismatch, expected %0h, got %0h", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    heap_result_t e;
    if (rst_ni && done_o) begin
      results_seen++;
      if (result_queue.size() == 0) begin
        $display("%0t: tb result word with nothing expected, status %0h prio %0h tag %0h",
                 $time, status_o, out_priority_o, out_tag_o);
        error_count++;
      end else begin
        e = result_queue.pop_front();
        check_field("status", 32'(e.status), 32'(status_o));
        check_field("out_priority", 32'(e.prio), 32'(out_priority_o));
        check_field("out_tag", 32'(e.tag), 32'(out_tag_o));
        check_field("occupancy", 32'(e.occ), 32'(occupancy_o));
      end
    end
  end

  // watchdog: too long with no word taken and no result seen ends the run
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: tb timeout, %0d cycles without progress", $time, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire

// File: max_heap_priority_queue_core.f
rtl/hpq_pkg.sv
rtl/hpq_ram.sv
rtl/hpq_fifo.sv
rtl/hpq_front.sv
rtl/hpq_back.sv
rtl/max_heap_priority_queue_core.sv
bench/max_heap_priority_queue_core_tb.sv
